### src/sc1a_pkg.sv
package sc1a_pkg;

    localparam int SC_W   = 8;
    localparam int KEY_W  = 7;
    localparam int CHAR_W = 7;
    localparam int ROM_AW = 6;

    // key codes (low 7 bits of a scancode)
    localparam logic [KEY_W-1:0] KEY_LSHIFT = 7'h2A;
    localparam logic [KEY_W-1:0] KEY_RSHIFT = 7'h36;
    localparam logic [KEY_W-1:0] KEY_CTRL   = 7'h1D;
    localparam logic [KEY_W-1:0] KEY_ALT    = 7'h38;
    localparam logic [KEY_W-1:0] KEY_CAPS   = 7'h3A;
    localparam logic [KEY_W-1:0] KEY_NUM    = 7'h45;
    localparam logic [KEY_W-1:0] KEY_ENTER  = 7'h1C;
    localparam logic [KEY_W-1:0] KEY_BKSP   = 7'h0E;
    localparam logic [KEY_W-1:0] KEY_TAB    = 7'h0F;
    localparam logic [KEY_W-1:0] KEY_SPACE  = 7'h39;

    localparam logic [CHAR_W-1:0] CH_NONE  = 7'h00;
    localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
    localparam logic [CHAR_W-1:0] CH_DEL   = 7'h7F;
    localparam logic [CHAR_W-1:0] CH_TAB   = 7'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_UC_A  = 7'h41;
    localparam logic [CHAR_W-1:0] CH_UC_Z  = 7'h5A;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 7'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z  = 7'h7A;

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
        logic num;
    } mod_state_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ascii_char;
        logic              char_valid;
        logic              caps_led;
        logic              num_led;
        logic              leds_changed;
        logic              ctrl_held;
        logic              alt_held;
    } xlate_result_t;

    function automatic logic alpha_key(input logic [ROM_AW-1:0] k);
        return (k >= 6'h10 && k <= 6'h19) || (k >= 6'h1E && k <= 6'h26) ||
               (k >= 6'h2C && k <= 6'h32);
    endfunction

    function automatic logic [CHAR_W-1:0] rom_lo(input logic [ROM_AW-1:0] k);
        logic [CHAR_W-1:0] c;
        case (k)
            6'h01: c = 7'h1B;  6'h02: c = 7'h31;  6'h03: c = 7'h32;  6'h04: c = 7'h33;
            6'h05: c = 7'h34;  6'h06: c = 7'h35;  6'h07: c = 7'h36;  6'h08: c = 7'h37;
            6'h09: c = 7'h38;  6'h0A: c = 7'h39;  6'h0B: c = 7'h30;  6'h0C: c = 7'h2D;
            6'h0D: c = 7'h3D;  6'h0E: c = 7'h08;
            6'h10: c = 7'h71;  6'h11: c = 7'h77;  6'h12: c = 7'h65;  6'h13: c = 7'h72;
            6'h14: c = 7'h74;  6'h15: c = 7'h79;  6'h16: c = 7'h75;  6'h17: c = 7'h69;
            6'h18: c = 7'h6F;  6'h19: c = 7'h70;  6'h1A: c = 7'h5B;  6'h1B: c = 7'h5D;
            6'h1C: c = 7'h0D;  6'h1E: c = 7'h61;  6'h1F: c = 7'h73;
            6'h20: c = 7'h64;  6'h21: c = 7'h66;  6'h22: c = 7'h67;  6'h23: c = 7'h68;
            6'h24: c = 7'h6A;  6'h25: c = 7'h6B;  6'h26: c = 7'h6C;  6'h27: c = 7'h3B;
            6'h28: c = 7'h27;  6'h29: c = 7'h60;  6'h2B: c = 7'h5C;  6'h2C: c = 7'h7A;
            6'h2D: c = 7'h78;  6'h2E: c = 7'h63;  6'h2F: c = 7'h76;
            6'h30: c = 7'h62;  6'h31: c = 7'h6E;  6'h32: c = 7'h6D;  6'h33: c = 7'h2C;
            6'h34: c = 7'h2E;  6'h35: c = 7'h2F;  6'h37: c = 7'h2A;  6'h39: c = 7'h20;
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] rom_hi(input logic [ROM_AW-1:0] k);
        logic [CHAR_W-1:0] c;
        case (k)
            6'h01: c = 7'h1B;  6'h02: c = 7'h21;  6'h03: c = 7'h40;  6'h04: c = 7'h23;
            6'h05: c = 7'h24;  6'h06: c = 7'h25;  6'h07: c = 7'h5E;  6'h08: c = 7'h26;
            6'h09: c = 7'h2A;  6'h0A: c = 7'h28;  6'h0B: c = 7'h29;  6'h0C: c = 7'h5F;
            6'h0D: c = 7'h2B;  6'h0E: c = 7'h08;
            6'h10: c = 7'h51;  6'h11: c = 7'h57;  6'h12: c = 7'h45;  6'h13: c = 7'h52;
            6'h14: c = 7'h54;  6'h15: c = 7'h59;  6'h16: c = 7'h55;  6'h17: c = 7'h49;
            6'h18: c = 7'h4F;  6'h19: c = 7'h50;  6'h1A: c = 7'h7B;  6'h1B: c = 7'h7D;
            6'h1C: c = 7'h0D;  6'h1E: c = 7'h41;  6'h1F: c = 7'h53;
            6'h20: c = 7'h44;  6'h21: c = 7'h46;  6'h22: c = 7'h47;  6'h23: c = 7'h48;
            6'h24: c = 7'h4A;  6'h25: c = 7'h4B;  6'h26: c = 7'h4C;  6'h27: c = 7'h3A;
            6'h28: c = 7'h22;  6'h29: c = 7'h7E;  6'h2B: c = 7'h7C;  6'h2C: c = 7'h5A;
            6'h2D: c = 7'h58;  6'h2E: c = 7'h43;  6'h2F: c = 7'h56;
            6'h30: c = 7'h42;  6'h31: c = 7'h4E;  6'h32: c = 7'h4D;  6'h33: c = 7'h3C;
            6'h34: c = 7'h3E;  6'h35: c = 7'h3F;  6'h37: c = 7'h2A;  6'h39: c = 7'h20;
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

endpackage

### src/sc1a_xlate.sv
module sc1a_xlate (
    input  logic [sc1a_pkg::SC_W-1:0] scancode,
    input  sc1a_pkg::mod_state_t      state_cur,
    output sc1a_pkg::mod_state_t      state_nxt,
    output sc1a_pkg::xlate_result_t   result
);
    import sc1a_pkg::*;

    logic [KEY_W-1:0]  key;
    logic [ROM_AW-1:0] idx;
    logic              release_code;
    logic              changed;
    logic              upper;
    logic [CHAR_W-1:0] tbl_char;
    logic [CHAR_W-1:0] ch;

    assign key          = scancode[KEY_W-1:0];
    assign idx          = key[ROM_AW-1:0];
    assign release_code = scancode[SC_W-1];

    assign upper    = state_cur.shift || (state_cur.caps && alpha_key(idx));
    assign tbl_char = upper ? rom_hi(idx) : rom_lo(idx);

    always_comb begin
        state_nxt = state_cur;
        changed   = 1'b0;
        ch        = CH_NONE;
        if (release_code) begin
            // 0xE0 lands here as key 0x60 and matches nothing
            if (key == KEY_LSHIFT || key == KEY_RSHIFT) state_nxt.shift = 1'b0;
            if (key == KEY_CTRL) state_nxt.ctrl = 1'b0;
            if (key == KEY_ALT)  state_nxt.alt  = 1'b0;
        end else begin
            unique case (key) inside
                KEY_ENTER: ch = CH_CR;
                KEY_BKSP:  ch = CH_DEL;
                KEY_TAB:   ch = CH_TAB;
                KEY_SPACE: ch = CH_SPACE;
                KEY_CAPS: begin
                    state_nxt.caps = !state_cur.caps;
                    changed        = 1'b1;
                end
                KEY_NUM: begin
                    state_nxt.num = !state_cur.num;
                    changed       = 1'b1;
                end
                KEY_LSHIFT, KEY_RSHIFT: state_nxt.shift = 1'b1;
                KEY_CTRL: state_nxt.ctrl = 1'b1;
                KEY_ALT:  state_nxt.alt  = 1'b1;
                default: begin
                    if (!key[KEY_W-1]) begin
                        ch = tbl_char;
                        // ctrl+letter: both cases map to 0x01..0x1A via low 5 bits
                        if (state_cur.ctrl &&
                            ((tbl_char >= CH_LC_A && tbl_char <= CH_LC_Z) ||
                             (tbl_char >= CH_UC_A && tbl_char <= CH_UC_Z))) begin
                            ch = {2'b00, tbl_char[4:0]};
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        result.ascii_char   = ch;
        result.char_valid   = (ch != CH_NONE);
        result.caps_led     = state_nxt.caps;
        result.num_led      = state_nxt.num;
        result.leds_changed = changed;
        result.ctrl_held    = state_nxt.ctrl;
        result.alt_held     = state_nxt.alt;
    end

endmodule

### src/scancode_set1_to_ascii_translator_unit.sv
// Set-1 scancode to ASCII translator. One scancode byte in, one result out,
// at a sustained rate of one beat per clock while m_ready stays high. A beat
// passes through an input register and then a result register, and waits in
// the first while the output stalls; the translation between them is a single
// table lookup plus the modifier update. Shift, ctrl, alt, caps and num lock
// state are kept inside and cleared by reset. Each result carries the character
// (zero for none), lock LEDs, a lock-toggle flag and the held ctrl and alt.
module scancode_set1_to_ascii_translator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sc1a_pkg::SC_W-1:0]     s_scancode,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sc1a_pkg::CHAR_W-1:0]   m_ascii_char,
    output logic                          m_char_valid,
    output logic                          m_caps_led,
    output logic                          m_num_led,
    output logic                          m_leds_changed,
    output logic                          m_ctrl_held,
    output logic                          m_alt_held
);
    import sc1a_pkg::*;

    logic              in_valid_reg;
    logic [SC_W-1:0]   in_sc_reg;
    logic              out_valid_reg;
    xlate_result_t     out_reg;
    mod_state_t        state_reg;
    mod_state_t        state_next;
    xlate_result_t     res_next;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    sc1a_xlate u_xlate (
        .scancode  (in_sc_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .result    (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) in_sc_reg <= s_scancode;
        if (advance)            out_reg   <= res_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_ascii_char   = out_reg.ascii_char;
    assign m_char_valid   = out_reg.char_valid;
    assign m_caps_led     = out_reg.caps_led;
    assign m_num_led      = out_reg.num_led;
    assign m_leds_changed = out_reg.leds_changed;
    assign m_ctrl_held    = out_reg.ctrl_held;
    assign m_alt_held     = out_reg.alt_held;

    // modifier state only moves when a beat is translated
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("modifier state changed without a beat");

    a_char_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_char_valid == (m_ascii_char != CH_NONE)))
        else $error("char_valid disagrees with ascii_char");

    a_lock_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_leds_changed) |-> !m_char_valid)
        else $error("lock toggle produced a character");

    a_caps_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_sc_reg == {1'b0, KEY_CAPS}) |=>
            (state_reg.caps != $past(state_reg.caps)))
        else $error("caps lock press did not toggle");

    a_led_match: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (out_reg.caps_led == state_reg.caps && out_reg.num_led == state_reg.num))
        else $error("reported LEDs differ from lock state");

endmodule
